@@ hw/rtl/lsra_pkg.sv @@
// Shared types and constants for the linear-scan register allocator.
// Depends on nothing; every other file in hw/rtl imports it.
package lsra_pkg;

    // Default sizes handed to the top level parameters
    localparam int ACTIVE_DEPTH_DEF = 32;
    localparam int REG_COUNT_DEF    = 16;

    // Field widths
    localparam int RESERVED_W = 16;
    localparam int SLOT_W     = 7;
    localparam int DATA_W     = 16;
    localparam int REGNUM_W   = 4;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // Register reset values
    localparam logic [RESERVED_W-1:0] RESERVED_RESET = 16'd144;
    localparam logic [SLOT_W-1:0]     SLOT_RESET     = 7'd8;

    // Register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_MASK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_BYTES    = 8'd1;

    // Largest stack depth, one bit wider than the depth counter
    localparam logic [DATA_W:0] MAX_DEPTH_BYTES = 17'd65535;

    // Request beat
    typedef struct packed {
        logic              first_of_function;
        logic [DATA_W-1:0] local_id;
        logic [DATA_W-1:0] inst_index;
        logic [DATA_W-1:0] last_read;
    } req_t;

    // Response beat
    typedef struct packed {
        logic                in_register;
        logic [REGNUM_W-1:0] register_number;
        logic [DATA_W-1:0]   stack_offset;
        logic [DATA_W-1:0]   frame_bytes;
        logic                overflow;
    } rsp_t;

    // One active interval held in a cell
    typedef struct packed {
        logic [DATA_W-1:0] last_read;
        logic              in_reg;
        logic [DATA_W-1:0] loc;     // register number or stack offset
    } entry_t;

    // Commands from the sequencer to the row of cells
    typedef struct packed {
        logic   pop;        // drop the head, everything moves one toward it
        logic   ins;        // sorted insert of ins_entry
        entry_t ins_entry;
    } chain_ctrl_t;

endpackage

@@ hw/rtl/lsra_cell.sv @@
// One cell of the sorted active list: holds one entry and moves it
// toward the head on a pop or toward the tail on an insert. Uses lsra_pkg.
module lsra_cell
    import lsra_pkg::*;
(
    input  logic        clk,
    input  chain_ctrl_t ctrl,
    input  logic        occ,         // this cell holds a live entry
    input  logic        left_le,     // left neighbor stays put on insert
    input  entry_t      left_entry,
    input  entry_t      right_entry,
    output entry_t      entry,
    output logic        le           // this cell stays put on insert
);

    entry_t entry_reg;
    entry_t entry_next;

    // Live entry with last use not above the new one keeps its place
    assign le = occ && (entry_reg.last_read <= ctrl.ins_entry.last_read);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.pop)
        begin
            entry_next = right_entry;
        end
        else if (ctrl.ins && !le)
        begin
            entry_next = left_le ? ctrl.ins_entry : left_entry;
        end
    end

    // Payload only, no reset
    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/lsra_chain.sv @@
// Row of lsra_cell instances forming the active list sorted by last use.
// Uses lsra_pkg and lsra_cell; occupancy comes from the live count.
module lsra_chain
    import lsra_pkg::*;
#(
    parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF,
    parameter int CNT_W        = $clog2(ACTIVE_DEPTH + 1)
)
(
    input  logic             clk,
    input  chain_ctrl_t      ctrl,
    input  logic [CNT_W-1:0] count,
    output entry_t           head
);

    entry_t entries [ACTIVE_DEPTH];
    logic   les     [ACTIVE_DEPTH];

    genvar i;
    generate
        for (i = 0; i < ACTIVE_DEPTH; i++)
        begin : g_cell
            logic   occ;
            logic   left_le;
            entry_t left_entry;
            entry_t right_entry;

            assign occ = count > CNT_W'(i);

            // Head cell: nothing to its left, the new entry enters there
            if (i == 0)
            begin : g_head
                assign left_le    = 1'b1;
                assign left_entry = ctrl.ins_entry;
            end
            else
            begin : g_body
                assign left_le    = les[i-1];
                assign left_entry = entries[i-1];
            end

            // Tail cell: what it takes on a pop is never live
            if (i == ACTIVE_DEPTH - 1)
            begin : g_tail
                assign right_entry = ctrl.ins_entry;
            end
            else
            begin : g_inner
                assign right_entry = entries[i+1];
            end

            lsra_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occ         (occ),
                .left_le     (left_le),
                .left_entry  (left_entry),
                .right_entry (right_entry),
                .entry       (entries[i]),
                .le          (les[i])
            );
        end
    endgenerate

    assign head = entries[0];

endmodule

@@ hw/rtl/linear_scan_register_allocator_core.sv @@
// Linear-scan register allocator: sequencer, register pool, stack depth
// tracking and config registers around the lsra_chain row of cells.
// Uses lsra_pkg, lsra_chain.
//
//   Channel | Signals                                  | Direction
//   --------+------------------------------------------+----------
//   request | req_valid, req_ready, req (req_t)        | in
//   result  | rsp_valid, rsp_ready, rsp (rsp_t)        | out
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data| in
//
// Flow: a request is latched in S_IDLE, then S_RUN retires the active entries whose
// last use lies before its index and then allocates; the list gives up one head entry per cycle.
// A request is taken only in idle; a pending result sits in the output
// register, and the next request is taken while it waits.
// A stalled result holds the final allocate cycle until the register frees.
// Reset: registers back to defaults, active list empty, no clearing pass.
module linear_scan_register_allocator_core
    import lsra_pkg::*;
#(
    parameter int ACTIVE_DEPTH = ACTIVE_DEPTH_DEF,
    parameter int REG_COUNT    = REG_COUNT_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    input  req_t                  req,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    output rsp_t                  rsp,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CNT_W = $clog2(ACTIVE_DEPTH + 1);
    localparam int RW    = $clog2(REG_COUNT);
    localparam int RNE   = (RW > REGNUM_W) ? RW : REGNUM_W;
    localparam int RM_W  = (REG_COUNT > RESERVED_W) ? REG_COUNT : RESERVED_W;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } state_t;

    state_t                state_reg, state_next;
    logic [RESERVED_W-1:0] reserved_reg, reserved_next;
    logic [SLOT_W-1:0]     slot_reg, slot_next;
    logic [REG_COUNT-1:0]  free_map_reg, free_map_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DATA_W-1:0]     asb_reg, asb_next;
    logic [DATA_W-1:0]     peak_reg, peak_next;
    logic [DATA_W-1:0]     idx_reg, idx_next;
    logic [DATA_W-1:0]     last_reg, last_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    rsp_t                  rsp_reg, rsp_next;

    chain_ctrl_t           ctrl;
    entry_t                head;

    logic [RM_W-1:0]       rsv_ext;
    logic [REG_COUNT-1:0]  rsv_vec;
    logic [REG_COUNT-1:0]  busy;
    logic                  got_found;
    logic [RW-1:0]         got_idx;
    logic [RNE-1:0]        got_ext;
    logic [DATA_W:0]       spill_sum;
    logic [DATA_W-1:0]     slot_ext;
    logic                  list_full;
    logic                  retire_hit;
    logic                  out_free;
    logic                  alloc;

    // Reserved mask sized to the register pool
    assign rsv_ext  = RM_W'(reserved_reg);
    assign rsv_vec  = rsv_ext[REG_COUNT-1:0];
    assign busy     = free_map_reg | rsv_vec;
    assign slot_ext = DATA_W'(slot_reg);

    // Lowest register neither taken nor reserved
    always_comb
    begin
        got_found = 1'b0;
        got_idx   = '0;
        for (int r = REG_COUNT - 1; r >= 0; r--)
        begin
            if (!busy[r])
            begin
                got_found = 1'b1;
                got_idx   = RW'(r);
            end
        end
    end

    assign got_ext    = RNE'(got_idx);
    assign spill_sum  = {1'b0, asb_reg} + {1'b0, slot_ext};
    assign list_full  = (count_reg == CNT_W'(ACTIVE_DEPTH));
    assign retire_hit = (state_reg == S_RUN) && (count_reg != '0)
                        && (head.last_read < idx_reg);
    assign out_free   = !rsp_valid_reg || rsp_ready;
    assign alloc      = (state_reg == S_RUN) && !retire_hit && out_free;

    // Sequencer, pool and depth update
    always_comb
    begin
        state_next     = state_reg;
        reserved_next  = reserved_reg;
        slot_next      = slot_reg;
        free_map_next  = free_map_reg;
        count_next     = count_reg;
        asb_next       = asb_reg;
        peak_next      = peak_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;

        ctrl.pop       = 1'b0;
        ctrl.ins       = 1'b0;
        ctrl.ins_entry = '{last_read: last_reg, in_reg: got_found,
                           loc: got_found ? DATA_W'(got_idx) : spill_sum[DATA_W-1:0]};

        // Config writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RESERVED_MASK: reserved_next = cfg_data[RESERVED_W-1:0];
                CFG_SLOT_BYTES:    slot_next     = cfg_data[SLOT_W-1:0];
                default:           ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    idx_next   = req.inst_index;
                    last_next  = req.last_read;
                    state_next = S_RUN;
                    if (req.first_of_function)
                    begin
                        free_map_next = rsv_vec;
                        count_next    = '0;
                        asb_next      = '0;
                        peak_next     = '0;
                    end
                end
            end

            S_RUN:
            begin
                if (retire_hit)
                begin
                    // Retire the head entry
                    ctrl.pop   = 1'b1;
                    count_next = count_reg - CNT_W'(1);
                    if (head.in_reg)
                    begin
                        free_map_next = free_map_reg
                            & ~(REG_COUNT'(1) << head.loc[RW-1:0]);
                    end
                    else if (asb_reg >= slot_ext)
                    begin
                        asb_next = asb_reg - slot_ext;
                    end
                    else
                    begin
                        asb_next = '0;
                    end
                end
                else if (alloc)
                begin
                    rsp_next.in_register     = 1'b0;
                    rsp_next.register_number = '0;
                    rsp_next.stack_offset    = '0;
                    rsp_next.overflow        = 1'b0;
                    rsp_next.frame_bytes     = peak_reg;
                    if (list_full)
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else if (got_found)
                    begin
                        free_map_next = free_map_reg | (REG_COUNT'(1) << got_idx);
                        count_next    = count_reg + CNT_W'(1);
                        ctrl.ins      = 1'b1;
                        rsp_next.in_register     = 1'b1;
                        rsp_next.register_number = got_ext[REGNUM_W-1:0];
                    end
                    else if (spill_sum > MAX_DEPTH_BYTES)
                    begin
                        rsp_next.overflow = 1'b1;
                    end
                    else
                    begin
                        asb_next   = spill_sum[DATA_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                        ctrl.ins   = 1'b1;
                        if (spill_sum[DATA_W-1:0] > peak_reg)
                        begin
                            peak_next            = spill_sum[DATA_W-1:0];
                            rsp_next.frame_bytes = spill_sum[DATA_W-1:0];
                        end
                        rsp_next.stack_offset = spill_sum[DATA_W-1:0];
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            reserved_reg  <= RESERVED_RESET;
            slot_reg      <= SLOT_RESET;
            free_map_reg  <= REG_COUNT'(RM_W'(RESERVED_RESET));
            count_reg     <= '0;
            asb_reg       <= '0;
            peak_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            reserved_reg  <= reserved_next;
            slot_reg      <= slot_next;
            free_map_reg  <= free_map_next;
            count_reg     <= count_next;
            asb_reg       <= asb_next;
            peak_reg      <= peak_next;
            rsp_valid_reg <= rsp_valid_next;
            rsp_reg       <= rsp_next;
        end
    end

    // Request fields
    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        last_reg <= last_next;
    end

    lsra_chain #(
        .ACTIVE_DEPTH (ACTIVE_DEPTH),
        .CNT_W        (CNT_W)
    ) u_chain (
        .clk   (clk),
        .ctrl  (ctrl),
        .count (count_reg),
        .head  (head)
    );

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ hw/rtl/lsra_checker.sv @@
// Port-level checks for linear_scan_register_allocator_core, bound below.
// Uses lsra_pkg.
module lsra_checker
    import lsra_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input rsp_t rsp
);

    // Stalled result beat holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("result beat changed while stalled");

    // One request in flight at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in flight");

    // Refused request carries no placement
    a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.overflow |-> !rsp.in_register
            && rsp.register_number == '0 && rsp.stack_offset == '0)
        else $error("overflow beat carries a placement");

    // A spill slot lies inside the peak frame
    a_spill_frame: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.in_register |-> rsp.stack_offset <= rsp.frame_bytes
            && rsp.register_number == '0)
        else $error("stack offset beyond frame size");

endmodule

bind linear_scan_register_allocator_core lsra_checker u_lsra_checker (.*);
